// File: hdl/vcsr_pkg.sv
// vcsr_pkg: shared types, field widths and reset constants of the voxel column span renderer
// no dependencies; every other file but vcsr_ram refers to it by scoped names
`default_nettype none

package vcsr_pkg;

	localparam int FRAC_W   = 16;
	localparam int HGT_W    = 16;
	localparam int RGB_W    = 24;
	localparam int CH_W     = 8;
	localparam int INVZ_W   = 24;
	localparam int EYE_W    = 24;
	localparam int HOR_W    = 12;
	localparam int SCR_W    = 11;
	localparam int COLS_W   = 12;
	localparam int OCC_W    = 11;
	localparam int CFG_W    = 24;
	localparam int CFG_IDX_W = 2;

	// bilinear weights are Q1.32 and may reach exactly one
	localparam int WGT_FRAC = 32;
	localparam int WGT_W    = WGT_FRAC + 1;
	localparam int ONE_W    = FRAC_W + 1;

	// projection: row = trunc(t / 2^23), saturated to a 13-bit signed range
	localparam int ROW_FRAC = 23;
	localparam int SROW_W   = 13;
	localparam int DIFF_W   = EYE_W + 1;
	localparam int PROJ_W   = 2 * DIFF_W;

	localparam logic signed [HOR_W-1:0] HORIZON_RESET = 12'sd510;
	localparam logic [EYE_W-1:0]        EYE_RESET     = 24'd19661;
	localparam logic [SCR_W-1:0]        SCREEN_RESET  = 11'd1080;
	localparam logic [COLS_W-1:0]       COLUMNS_RESET = 12'd1920;

	typedef enum logic {
		OP_FRAME  = 1'b0,
		OP_SAMPLE = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HORIZON = 2'd0,
		CFG_EYE     = 2'd1,
		CFG_SCREEN  = 2'd2,
		CFG_COLUMNS = 2'd3
	} cfg_index_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [INVZ_W-1:0]   inv_z;
		logic [FRAC_W-1:0]   fract_x;
		logic [FRAC_W-1:0]   fract_y;
		logic [HGT_W-1:0]    height_00;
		logic [HGT_W-1:0]    height_10;
		logic [HGT_W-1:0]    height_01;
		logic [HGT_W-1:0]    height_11;
		logic [RGB_W-1:0]    rgb_00;
		logic [RGB_W-1:0]    rgb_10;
		logic [RGB_W-1:0]    rgb_01;
		logic [RGB_W-1:0]    rgb_11;
	} sample_t;

	typedef struct packed {
		logic [OCC_W-1:0] column;
		logic [OCC_W-1:0] top_row;
		logic [OCC_W-1:0] bottom_row;
		logic [CH_W-1:0]  red;
		logic [CH_W-1:0]  green;
		logic [CH_W-1:0]  blue;
	} span_t;

	// control that travels with each item down the pipeline
	typedef struct packed {
		logic valid;
		logic frame;
	} tag_t;

endpackage

`default_nettype wire

// File: hdl/vcsr_ram.sv
// vcsr_ram: generic simple dual-port RAM, one write and one registered read port
// read returns the old word on a same-address write; no dependencies
`default_nettype none

module vcsr_ram #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hdl/vcsr_interp.sv
// vcsr_interp: stages 1 to 3, bilinear weights, corner products and blended height and colour
// depends on vcsr_pkg; ends with eye height minus interpolated height
`default_nettype none

module vcsr_interp #(
	parameter int COL_W = 11
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              advance,
	input  wire vcsr_pkg::tag_t                    tag_in,
	input  wire vcsr_pkg::sample_t                 sample_in,
	input  wire logic [COL_W-1:0]                  col_in,
	input  wire logic [vcsr_pkg::EYE_W-1:0]        eye_height,
	output      vcsr_pkg::tag_t                    tag_s3,
	output      logic [COL_W-1:0]                  col_s3,
	output      logic [vcsr_pkg::INVZ_W-1:0]       inv_z_s3,
	output      logic signed [vcsr_pkg::DIFF_W-1:0] diff_s3,
	output      logic [vcsr_pkg::RGB_W-1:0]        color_s3
);

	localparam int WGT_W = vcsr_pkg::WGT_W;
	localparam int HP_W  = vcsr_pkg::HGT_W + WGT_W;
	localparam int HS_W  = HP_W + 2;
	localparam int CP_W  = vcsr_pkg::CH_W + WGT_W;
	localparam int CS_W  = CP_W + 2;
	localparam int ONE_W = vcsr_pkg::ONE_W;

	logic [ONE_W-1:0]          nfx, nfy, fx, fy;
	logic [vcsr_pkg::HGT_W-1:0] hgt [4];
	logic [vcsr_pkg::RGB_W-1:0] rgb [4];

	vcsr_pkg::tag_t             tag_s1, tag_s2;
	logic [COL_W-1:0]           col_s1, col_s2;
	logic [vcsr_pkg::INVZ_W-1:0] inv_z_s1, inv_z_s2;
	logic [WGT_W-1:0]           w_s1 [4];
	logic [vcsr_pkg::HGT_W-1:0] hgt_s1 [4];
	logic [vcsr_pkg::RGB_W-1:0] rgb_s1 [4];
	logic [HP_W-1:0]            hp_s2 [4];
	logic [CP_W-1:0]            cp_s2 [3][4];

	logic [HS_W-1:0]            hsum;
	logic [CS_W-1:0]            csum [3];
	logic [vcsr_pkg::HGT_W-1:0] h_blend;

	assign fx  = ONE_W'(sample_in.fract_x);
	assign fy  = ONE_W'(sample_in.fract_y);
	assign nfx = (ONE_W'(1) << vcsr_pkg::FRAC_W) - fx;
	assign nfy = (ONE_W'(1) << vcsr_pkg::FRAC_W) - fy;

	assign hgt[0] = sample_in.height_00;
	assign hgt[1] = sample_in.height_10;
	assign hgt[2] = sample_in.height_01;
	assign hgt[3] = sample_in.height_11;
	assign rgb[0] = sample_in.rgb_00;
	assign rgb[1] = sample_in.rgb_10;
	assign rgb[2] = sample_in.rgb_01;
	assign rgb[3] = sample_in.rgb_11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else if (advance) begin
			tag_s1 <= tag_in;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	// stage 1: weights
	always_ff @(posedge clk) begin
		if (advance) begin
			col_s1   <= col_in;
			inv_z_s1 <= sample_in.inv_z;
			w_s1[0]  <= WGT_W'(nfx) * WGT_W'(nfy);
			w_s1[1]  <= WGT_W'(fx) * WGT_W'(nfy);
			w_s1[2]  <= WGT_W'(nfx) * WGT_W'(fy);
			w_s1[3]  <= WGT_W'(fx) * WGT_W'(fy);
			for (int k = 0; k < 4; k++) begin
				hgt_s1[k] <= hgt[k];
				rgb_s1[k] <= rgb[k];
			end
		end
	end

	// stage 2: corner products
	always_ff @(posedge clk) begin
		if (advance) begin
			col_s2   <= col_s1;
			inv_z_s2 <= inv_z_s1;
			for (int k = 0; k < 4; k++) begin
				hp_s2[k] <= HP_W'(hgt_s1[k]) * HP_W'(w_s1[k]);
				for (int ch = 0; ch < 3; ch++) begin
					cp_s2[ch][k] <= CP_W'(rgb_s1[k][(2 - ch) * vcsr_pkg::CH_W +: vcsr_pkg::CH_W])
						* CP_W'(w_s1[k]);
				end
			end
		end
	end

	// stage 3: sums, drop weight fraction
	always_comb begin
		hsum = HS_W'(hp_s2[0]) + HS_W'(hp_s2[1]) + HS_W'(hp_s2[2]) + HS_W'(hp_s2[3]);
		for (int ch = 0; ch < 3; ch++) begin
			csum[ch] = CS_W'(cp_s2[ch][0]) + CS_W'(cp_s2[ch][1])
				+ CS_W'(cp_s2[ch][2]) + CS_W'(cp_s2[ch][3]);
		end
	end

	assign h_blend = hsum[vcsr_pkg::WGT_FRAC +: vcsr_pkg::HGT_W];

	always_ff @(posedge clk) begin
		if (advance) begin
			col_s3   <= col_s2;
			inv_z_s3 <= inv_z_s2;
			diff_s3  <= $signed({1'b0, eye_height})
				- $signed(vcsr_pkg::DIFF_W'(h_blend));
			color_s3 <= {csum[0][vcsr_pkg::WGT_FRAC +: vcsr_pkg::CH_W],
				csum[1][vcsr_pkg::WGT_FRAC +: vcsr_pkg::CH_W],
				csum[2][vcsr_pkg::WGT_FRAC +: vcsr_pkg::CH_W]};
		end
	end

endmodule

`default_nettype wire

// File: hdl/vcsr_project.sv
// vcsr_project: stages 4 and 5, perspective multiply and screen row with saturation
// depends on vcsr_pkg; fed by vcsr_interp
`default_nettype none

module vcsr_project #(
	parameter int COL_W = 11
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               advance,
	input  wire vcsr_pkg::tag_t                     tag_s3,
	input  wire logic [COL_W-1:0]                   col_s3,
	input  wire logic [vcsr_pkg::INVZ_W-1:0]        inv_z_s3,
	input  wire logic signed [vcsr_pkg::DIFF_W-1:0] diff_s3,
	input  wire logic [vcsr_pkg::RGB_W-1:0]         color_s3,
	input  wire logic signed [vcsr_pkg::HOR_W-1:0]  horizon_row,
	output      logic [COL_W-1:0]                   col_s4,
	output      vcsr_pkg::tag_t                     tag_s5,
	output      logic [COL_W-1:0]                   col_s5,
	output      logic signed [vcsr_pkg::SROW_W-1:0] row_s5,
	output      logic [vcsr_pkg::RGB_W-1:0]         color_s5
);

	localparam int PROJ_W = vcsr_pkg::PROJ_W;
	localparam int T_W    = PROJ_W + 1;
	localparam logic signed [T_W-1:0] BIAS    = (T_W'(1) <<< vcsr_pkg::ROW_FRAC) - T_W'(1);
	localparam logic signed [T_W-1:0] ROW_MAX = T_W'(4095);
	localparam logic signed [T_W-1:0] ROW_MIN = -T_W'(4096);

	vcsr_pkg::tag_t              tag_s4;
	logic signed [PROJ_W-1:0]    proj_s4;
	logic [vcsr_pkg::RGB_W-1:0]  color_s4;

	logic signed [T_W-1:0] t_raw, t_biased, quot;
	logic signed [vcsr_pkg::SROW_W-1:0] row_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s4 <= '0;
			tag_s5 <= '0;
		end else if (advance) begin
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
		end
	end

	// stage 4: (eye - h) * inv_z
	always_ff @(posedge clk) begin
		if (advance) begin
			col_s4   <= col_s3;
			color_s4 <= color_s3;
			proj_s4  <= PROJ_W'(diff_s3) * PROJ_W'($signed({1'b0, inv_z_s3}));
		end
	end

	// stage 5: add horizon, truncate toward zero, saturate
	always_comb begin
		t_raw    = T_W'(proj_s4) + (T_W'(horizon_row) <<< vcsr_pkg::ROW_FRAC);
		t_biased = t_raw[T_W-1] ? t_raw + BIAS : t_raw;
		quot     = t_biased >>> vcsr_pkg::ROW_FRAC;
		priority if (quot > ROW_MAX) begin
			row_sat = ROW_MAX[vcsr_pkg::SROW_W-1:0];
		end else if (quot < ROW_MIN) begin
			row_sat = ROW_MIN[vcsr_pkg::SROW_W-1:0];
		end else begin
			row_sat = quot[vcsr_pkg::SROW_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			col_s5   <= col_s4;
			color_s5 <= color_s4;
			row_s5   <= row_sat;
		end
	end

endmodule

`default_nettype wire

// File: hdl/vcsr_occlude.sv
// vcsr_occlude: occlusion row memory, per-row valid bits, depth test and span output register
// depends on vcsr_pkg and vcsr_ram; fed by vcsr_project
`default_nettype none

module vcsr_occlude #(
	parameter int MAX_COLUMNS = 2048
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               advance,
	input  wire logic [$clog2(MAX_COLUMNS)-1:0]     col_s4,
	input  wire vcsr_pkg::tag_t                     tag_s5,
	input  wire logic [$clog2(MAX_COLUMNS)-1:0]     col_s5,
	input  wire logic signed [vcsr_pkg::SROW_W-1:0] row_s5,
	input  wire logic [vcsr_pkg::RGB_W-1:0]         color_s5,
	input  wire logic [vcsr_pkg::SCR_W-1:0]         screen_height,
	output      logic                               span_valid,
	output      vcsr_pkg::span_t                    span
);

	localparam int OCC_W   = vcsr_pkg::OCC_W;
	localparam int COL_W   = $clog2(MAX_COLUMNS);
	localparam int LANE_W  = (COL_W > 8) ? COL_W - 8 : 0;
	localparam int LANES   = 1 << LANE_W;
	localparam int LANE_IW = (LANE_W > 0) ? LANE_W : 1;
	localparam int ROW_AW  = COL_W - LANE_W;
	localparam int ROWS    = (MAX_COLUMNS + LANES - 1) / LANES;
	localparam int WORD_W  = LANES * OCC_W;

	typedef logic [LANES-1:0][OCC_W-1:0] word_t;

	logic [ROWS-1:0]        row_valid_q;
	logic [OCC_W-1:0]       frame_h_q;
	logic                   fwd_hit_q;
	word_t                  fwd_word_q;
	logic [WORD_W-1:0]      ram_rdata;

	logic [ROW_AW-1:0]      rd_row, wr_row;
	logic [LANE_IW-1:0]     lane;
	word_t                  rd_word, cur_word, wr_word;
	logic [OCC_W-1:0]       old_row, top;
	logic                   hit, wr_en, frame_go;
	logic [COL_W+OCC_W-1:0] col_ext;

	assign rd_row = ROW_AW'(col_s4 >> LANE_W);
	assign wr_row = ROW_AW'(col_s5 >> LANE_W);
	assign lane   = LANE_IW'(col_s5 % LANES);

	// newest copy of the row: the write of the item just ahead bypasses the ram
	assign rd_word = fwd_hit_q ? fwd_word_q : word_t'(ram_rdata);

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			cur_word[l] = row_valid_q[wr_row] ? rd_word[l] : frame_h_q;
		end
	end

	assign old_row  = cur_word[lane];
	assign hit      = tag_s5.valid && !tag_s5.frame
		&& (row_s5 < $signed({2'b00, old_row}));
	assign top      = row_s5[vcsr_pkg::SROW_W-1] ? '0 : row_s5[OCC_W-1:0];
	assign wr_en    = advance && hit;
	assign frame_go = advance && tag_s5.valid && tag_s5.frame;

	always_comb begin
		wr_word       = cur_word;
		wr_word[lane] = top;
	end

	vcsr_ram #(
		.WIDTH(WORD_W),
		.DEPTH(ROWS)
	) u_rows (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_row),
		.wdata (wr_word),
		.re    (advance),
		.raddr (rd_row),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			frame_h_q   <= vcsr_pkg::SCREEN_RESET;
			fwd_hit_q   <= 1'b0;
			span_valid  <= 1'b0;
		end else begin
			if (frame_go) begin
				row_valid_q <= '0;
				frame_h_q   <= screen_height;
			end else if (wr_en) begin
				row_valid_q[wr_row] <= 1'b1;
			end
			if (advance) begin
				fwd_hit_q  <= wr_en && (wr_row == rd_row);
				span_valid <= hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fwd_word_q <= wr_word;
		end
	end

	assign col_ext = (COL_W + OCC_W)'(col_s5);

	always_ff @(posedge clk) begin
		if (advance && hit) begin
			span.column     <= col_ext[OCC_W-1:0];
			span.top_row    <= top;
			span.bottom_row <= old_row;
			span.red        <= color_s5[2 * vcsr_pkg::CH_W +: vcsr_pkg::CH_W];
			span.green      <= color_s5[vcsr_pkg::CH_W +: vcsr_pkg::CH_W];
			span.blue       <= color_s5[0 +: vcsr_pkg::CH_W];
		end
	end

endmodule

`default_nettype wire

// File: hdl/voxel_column_span_renderer.sv
// voxel_column_span_renderer: top level, configuration registers, column counter, pipeline glue
// depends on vcsr_pkg, vcsr_interp, vcsr_project, vcsr_occlude
//
// usage:
//  - sample channel (sample_valid/sample_ready/sample): opcode 0 starts a frame, opcode 1 is
//    one terrain sample for the next screen column
//  - span channel (span_valid/span_ready/span): at most one span per sample item, none for a
//    frame start or for a sample hidden behind what is already drawn in its column
//  - cfg port (cfg_we/cfg_index/cfg_data): single-cycle register writes, only while idle
//  - six-stage pipeline: weights, corner products, blend, projection multiply, row
//    saturation, depth test and output register, in that order; span_valid is the valid
//    bit of the output register
//  - one item per cycle unless stalled, set by one read and one write of the occlusion ram
//  - the occlusion ram holds eight columns per word with a valid bit per word, so a frame
//    start clears every valid bit at once; the previous item's write is bypassed into the read
//  - when span_valid is high and span_ready low the whole pipeline holds, sample_ready
//    drops, and nothing is lost or repeated
//  - reset loads the register defaults, zeroes the column counter and marks every column
//    open down to 1080 rows; no clearing pass is needed
`default_nettype none

module voxel_column_span_renderer #(
	parameter int MAX_COLUMNS = 2048
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              sample_valid,
	output      logic                              sample_ready,
	input  wire vcsr_pkg::sample_t                 sample,
	output      logic                              span_valid,
	input  wire logic                              span_ready,
	output      vcsr_pkg::span_t                   span,
	input  wire logic                              cfg_we,
	input  wire logic [vcsr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vcsr_pkg::CFG_W-1:0]        cfg_data
);

	localparam int COL_W = $clog2(MAX_COLUMNS);
	localparam int LIM_W = (COL_W + 1 > vcsr_pkg::COLS_W) ? COL_W + 1 : vcsr_pkg::COLS_W;
	localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(MAX_COLUMNS);

	logic signed [vcsr_pkg::HOR_W-1:0] horizon_q;
	logic [vcsr_pkg::EYE_W-1:0]        eye_q;
	logic [vcsr_pkg::SCR_W-1:0]        screen_q;
	logic [vcsr_pkg::COLS_W-1:0]       columns_q;
	logic [COL_W-1:0]                  col_cnt_q;

	logic                  advance, accept;
	logic [LIM_W-1:0]      cols_ext, limit, next_ext;
	vcsr_pkg::tag_t        tag_in, tag_s3, tag_s5;
	logic [COL_W-1:0]      col_s3, col_s4, col_s5;
	logic [vcsr_pkg::INVZ_W-1:0]         inv_z_s3;
	logic signed [vcsr_pkg::DIFF_W-1:0]  diff_s3;
	logic [vcsr_pkg::RGB_W-1:0]          color_s3, color_s5;
	logic signed [vcsr_pkg::SROW_W-1:0]  row_s5;

	assign advance      = !span_valid || span_ready;
	assign sample_ready = advance;
	assign accept       = sample_valid && advance;

	assign tag_in.valid = sample_valid;
	assign tag_in.frame = (sample.opcode == vcsr_pkg::OP_FRAME);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horizon_q <= vcsr_pkg::HORIZON_RESET;
			eye_q     <= vcsr_pkg::EYE_RESET;
			screen_q  <= vcsr_pkg::SCREEN_RESET;
			columns_q <= vcsr_pkg::COLUMNS_RESET;
		end else if (cfg_we) begin
			unique case (vcsr_pkg::cfg_index_t'(cfg_index))
				vcsr_pkg::CFG_HORIZON: horizon_q <= cfg_data[vcsr_pkg::HOR_W-1:0];
				vcsr_pkg::CFG_EYE:     eye_q     <= cfg_data[vcsr_pkg::EYE_W-1:0];
				vcsr_pkg::CFG_SCREEN:  screen_q  <= cfg_data[vcsr_pkg::SCR_W-1:0];
				vcsr_pkg::CFG_COLUMNS: columns_q <= cfg_data[vcsr_pkg::COLS_W-1:0];
				default: ;
			endcase
		end
	end

	// column wraps at columns in use, zero or too many means all columns
	assign cols_ext = LIM_W'(columns_q);
	assign limit    = (cols_ext == '0 || cols_ext > LIM_MAX) ? LIM_MAX : cols_ext;
	assign next_ext = LIM_W'(col_cnt_q) + LIM_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
		end else if (accept) begin
			if (tag_in.frame || next_ext >= limit) begin
				col_cnt_q <= '0;
			end else begin
				col_cnt_q <= next_ext[COL_W-1:0];
			end
		end
	end

	vcsr_interp #(
		.COL_W(COL_W)
	) u_interp (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.tag_in     (tag_in),
		.sample_in  (sample),
		.col_in     (col_cnt_q),
		.eye_height (eye_q),
		.tag_s3     (tag_s3),
		.col_s3     (col_s3),
		.inv_z_s3   (inv_z_s3),
		.diff_s3    (diff_s3),
		.color_s3   (color_s3)
	);

	vcsr_project #(
		.COL_W(COL_W)
	) u_project (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.tag_s3      (tag_s3),
		.col_s3      (col_s3),
		.inv_z_s3    (inv_z_s3),
		.diff_s3     (diff_s3),
		.color_s3    (color_s3),
		.horizon_row (horizon_q),
		.col_s4      (col_s4),
		.tag_s5      (tag_s5),
		.col_s5      (col_s5),
		.row_s5      (row_s5),
		.color_s5    (color_s5)
	);

	vcsr_occlude #(
		.MAX_COLUMNS(MAX_COLUMNS)
	) u_occlude (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.col_s4        (col_s4),
		.tag_s5        (tag_s5),
		.col_s5        (col_s5),
		.row_s5        (row_s5),
		.color_s5      (color_s5),
		.screen_height (screen_q),
		.span_valid    (span_valid),
		.span          (span)
	);

endmodule

`default_nettype wire
